// ===== rtl/dmcg_pkg.sv =====
package dmcg_pkg;

	// Default build parameters of the generator.
	localparam int DEF_INDEX_BITS     = 20;
	localparam int DEF_COS_TABLE_BITS = 10;
	localparam int DEF_OUT_BITS       = 16;

	// Rotation algorithm constants, angles in cycles scaled by 2^32.
	localparam int    CORDIC_STEPS    = 30;
	localparam longint Q30_ONE        = 64'sd1 << 30;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

	localparam longint ATAN_CYC [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	// Register map, word index taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_CARRIER_STEP  = 2'd0,
		REG_ROTATION_STEP = 2'd1,
		REG_MOD_DEPTH     = 2'd2
	} reg_idx_t;

	// Quadrant of a phase, from its top two bits.
	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// Runs the rotation for a first-quadrant angle and returns the cosine leg
	// (or the sine leg) in Q30, clamped to plus or minus one. This is only
	// evaluated at elaboration to fill the lookup tables.
	function automatic logic signed [31:0] cordic_leg(input logic [31:0] phase_z,
		input logic pick_y);
		longint x_c;
		longint y_c;
		longint z_c;
		longint dx;
		longint dy;
		longint r_c;
		int     i;
		x_c = CORDIC_GAIN_Q30;
		y_c = 0;
		z_c = longint'({32'd0, phase_z});
		for (i = 0; i < CORDIC_STEPS; i++) begin
			dx = y_c >>> i;
			dy = x_c >>> i;
			if (z_c >= 0) begin
				x_c = x_c - dx;
				y_c = y_c + dy;
				z_c = z_c - ATAN_CYC[i];
			end else begin
				x_c = x_c + dx;
				y_c = y_c - dy;
				z_c = z_c + ATAN_CYC[i];
			end
		end
		r_c = pick_y ? y_c : x_c;
		if (r_c > Q30_ONE) begin
			r_c = Q30_ONE;
		end
		if (r_c < -Q30_ONE) begin
			r_c = -Q30_ONE;
		end
		return r_c[31:0];
	endfunction

	// Unfolds a first-quadrant cosine and sine pair into the cosine of the
	// full phase.
	function automatic logic signed [31:0] quad_pick(input logic signed [31:0] cos_v,
		input logic signed [31:0] sin_v, input quad_t quad);
		logic signed [31:0] r_v;
		unique case (quad)
			QUAD_I:   r_v = cos_v;
			QUAD_II:  r_v = -sin_v;
			QUAD_III: r_v = -cos_v;
			QUAD_IV:  r_v = sin_v;
			default:  r_v = cos_v;
		endcase
		return r_v;
	endfunction

endpackage

// ===== rtl/doppler_modulated_cosine_gen.sv =====
// Phase-modulated cosine generator.
// The sample channel (sample_valid, sample_ready, sample_index) carries one
// sample index per request; the wave channel (wave_valid, wave_ready,
// wave_sample) returns cos(2*pi*(n*carrier_step - depth*(1 - cos(n*rotation_step))))
// as a signed Q1.(OUT_BITS-1) value, one result for each request, in order.
// Carrier step, rotation step and modulation depth are written over the
// APB-style port at byte addresses 0, 4 and 8 and read back at the same places.
// The datapath is a six-stage pipeline: index multiplies, rotation cosine
// lookup, quadrant unfold, depth multiply, phase subtract with final lookup,
// then quadrant unfold, rounding and saturation into the output register.
// A request accepted into stage 1 passes through each stage register in turn,
// and its result is held on wave_sample by the stage 6 register; one request
// is taken in every cycle while wave_ready is high.
// When wave_ready is low, the stages close up over their empty
// slots and then hold; sample_ready falls only once every stage is full.
// Reset clears all pipeline valid bits and sets the three registers to zero.
module doppler_modulated_cosine_gen
	import dmcg_pkg::*;
#(
	parameter int INDEX_BITS     = DEF_INDEX_BITS,
	parameter int COS_TABLE_BITS = DEF_COS_TABLE_BITS,
	parameter int OUT_BITS       = DEF_OUT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Sample index channel.
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [INDEX_BITS-1:0]  sample_index,
	// Wave output channel.
	output logic                   wave_valid,
	input  logic                   wave_ready,
	output logic [OUT_BITS-1:0]    wave_sample
);

	localparam int ADDR_W = COS_TABLE_BITS - 2;
	localparam int TAB_N  = 1 << ADDR_W;
	localparam int SHIFT  = 31 - OUT_BITS;
	localparam logic signed [32:0] ROUND_HALF = 33'sd1 <<< (SHIFT - 1);
	localparam logic signed [32:0] OUT_LIM    = (33'sd1 <<< (OUT_BITS - 1)) - 33'sd1;
	localparam logic [31:0]        Q30_U      = 32'h4000_0000;

	// Configuration registers.
	logic [31:0] carrier_step_q;
	logic [31:0] rotation_step_q;
	logic [31:0] mod_depth_q;
	logic        cfg_write;
	reg_idx_t    cfg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q  <= '0;
			rotation_step_q <= '0;
			mod_depth_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_CARRIER_STEP:  carrier_step_q  <= pwdata;
				REG_ROTATION_STEP: rotation_step_q <= pwdata;
				REG_MOD_DEPTH:     mod_depth_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (cfg_idx)
			REG_CARRIER_STEP:  prdata = carrier_step_q;
			REG_ROTATION_STEP: prdata = rotation_step_q;
			REG_MOD_DEPTH:     prdata = mod_depth_q;
			default:           prdata = '0;
		endcase
	end

	// First-quadrant cosine and sine tables, filled at elaboration.
	logic signed [31:0] cos_tab [TAB_N];
	logic signed [31:0] sin_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_rom
		localparam logic [31:0]        Z_G   = 32'(g) << (32 - COS_TABLE_BITS);
		localparam logic signed [31:0] COS_G = cordic_leg(Z_G, 1'b0);
		localparam logic signed [31:0] SIN_G = cordic_leg(Z_G, 1'b1);
		assign cos_tab[g] = COS_G;
		assign sin_tab[g] = SIN_G;
	end

	// Stage enables: a stage loads when it is empty or its successor moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || wave_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign sample_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: carrier and rotation phases, both wrapping modulo one cycle.
	logic [31:0] index_ext;
	logic [31:0] carrier_s1;
	logic [31:0] rot_s1;

	assign index_ext = 32'(sample_index);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			carrier_s1 <= index_ext * carrier_step_q;
			rot_s1     <= index_ext * rotation_step_q;
		end
	end

	// Stage 2: table read for the rotation cosine.
	logic [ADDR_W-1:0]  rot_addr;
	logic signed [31:0] rot_cos_s2;
	logic signed [31:0] rot_sin_s2;
	quad_t              rot_quad_s2;
	logic [31:0]        carrier_s2;

	assign rot_addr = rot_s1[29 -: ADDR_W];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rot_cos_s2  <= cos_tab[rot_addr];
			rot_sin_s2  <= sin_tab[rot_addr];
			rot_quad_s2 <= quad_t'(rot_s1[31:30]);
			carrier_s2  <= carrier_s1;
		end
	end

	// Stage 3: unfold the quadrant and form one minus the cosine, in Q30.
	logic signed [31:0] rot_c;
	logic [31:0]        one_minus_s3;
	logic [31:0]        carrier_s3;

	assign rot_c = quad_pick(rot_cos_s2, rot_sin_s2, rot_quad_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			one_minus_s3 <= Q30_U - rot_c;
			carrier_s3   <= carrier_s2;
		end
	end

	// Stage 4: depth times the Q30 term, rescaled to cycles over 2^32.
	logic [63:0] mod_prod;
	logic [31:0] modp_s4;
	logic [31:0] carrier_s4;

	assign mod_prod = 64'(mod_depth_q) * 64'(one_minus_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			modp_s4    <= mod_prod[53:22];
			carrier_s4 <= carrier_s3;
		end
	end

	// Stage 5: modulated phase and its table read.
	logic [31:0]        total;
	logic [ADDR_W-1:0]  total_addr;
	logic signed [31:0] out_cos_s5;
	logic signed [31:0] out_sin_s5;
	quad_t              out_quad_s5;

	assign total      = carrier_s4 - modp_s4;
	assign total_addr = total[29 -: ADDR_W];

	always_ff @(posedge clk) begin
		if (en_s5) begin
			out_cos_s5  <= cos_tab[total_addr];
			out_sin_s5  <= sin_tab[total_addr];
			out_quad_s5 <= quad_t'(total[31:30]);
		end
	end

	// Stage 6: unfold the quadrant, round half an output step up, floor, then saturate.
	logic signed [31:0] out_c;
	logic signed [32:0] out_rnd;
	logic signed [32:0] out_shr;
	logic signed [32:0] out_sat;
	logic [OUT_BITS-1:0] wave_s6;

	assign out_c   = quad_pick(out_cos_s5, out_sin_s5, out_quad_s5);
	assign out_rnd = {out_c[31], out_c} + ROUND_HALF;
	assign out_shr = out_rnd >>> SHIFT;

	always_comb begin
		priority if (out_shr > OUT_LIM) begin
			out_sat = OUT_LIM;
		end else if (out_shr < -OUT_LIM) begin
			out_sat = -OUT_LIM;
		end else begin
			out_sat = out_shr;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			wave_s6 <= out_sat[OUT_BITS-1:0];
		end
	end

	assign wave_valid  = v_s6;
	assign wave_sample = wave_s6;

	// A stage that is held keeps its contents for the next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s4) |=> (v_s3 && $stable(one_minus_s3)))
		else $error("stage 3 changed while stalled");

	// The first stage only fills from an accepted request.
	a_fill_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !(sample_valid && sample_ready)) |=> !v_s1)
		else $error("stage 1 filled without a request");

	// An empty first stage always takes a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> sample_ready)
		else $error("request refused with stage 1 empty");

	// A full stage behind a stalled output is not overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && v_s6 && !wave_ready) |-> !en_s5)
		else $error("stage 5 overwritten during stall");

	// One minus a clamped cosine lies between zero and two, in Q30.
	a_one_minus_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (one_minus_s3 <= 32'h8000_0000))
		else $error("modulation term out of range");

endmodule

// ===== tb/doppler_modulated_cosine_gen_test.sv =====
`timescale 1ns / 1ps

module doppler_modulated_cosine_gen_test;
	import dmcg_pkg::*;

	localparam int IDX_W = DEF_INDEX_BITS;
	localparam int TABLE_W = DEF_COS_TABLE_BITS;
	localparam int WAVE_W = DEF_OUT_BITS;
	localparam int ROUND_SHIFT = 31 - WAVE_W;
	localparam longint WAVE_LIMIT = (64'sd1 <<< (WAVE_W - 1)) - 1;

	// Word index that lies outside the register map.
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	localparam int IDLE_PERCENT = 18;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AFTER_WAVES = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_REQUESTS = 240;
	localparam int MAX_REPORTS = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [IDX_W-1:0] sample_index = '0;
	logic wave_valid;
	logic wave_ready = 1'b0;
	logic [WAVE_W-1:0] wave_sample;

	// Register copies for the predictor.
	logic [31:0] cfg_carrier = '0;
	logic [31:0] cfg_rotation = '0;
	logic [31:0] cfg_depth = '0;

	logic [IDX_W-1:0] pending_indices[$];
	logic signed [WAVE_W-1:0] expected_waves[$];
	int error_count = 0;
	int waves_seen = 0;
	int hold_left = 0;
	logic steady = 1'b0;

	doppler_modulated_cosine_gen DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_index(sample_index),
		.wave_valid(wave_valid),
		.wave_ready(wave_ready),
		.wave_sample(wave_sample)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cosine of a phase in cycles scaled by 2^32, Q30, after truncation to the
	// table resolution, quadrant folding and a rotation-based evaluation.
	function automatic longint phase_cosine(input logic [31:0] phase);
		logic [31:0] coarse;
		quad_t quad;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint r;
		int i;
		coarse = phase & ~((32'd1 << (32 - TABLE_W)) - 32'd1);
		quad = quad_t'(coarse[31:30]);
		x = CORDIC_GAIN_Q30;
		y = 0;
		z = longint'({34'd0, coarse[29:0]});
		for (i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_CYC[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_CYC[i];
			end
		end
		case (quad)
			QUAD_I: begin
				r = x;
			end
			QUAD_II: begin
				r = -y;
			end
			QUAD_III: begin
				r = -x;
			end
			default: begin
				r = y;
			end
		endcase
		if (r > Q30_ONE) begin
			r = Q30_ONE;
		end
		if (r < -Q30_ONE) begin
			r = -Q30_ONE;
		end
		return r;
	endfunction

	// Output sample for one index under the current register settings.
	function automatic logic signed [WAVE_W-1:0] predict_wave(input logic [IDX_W-1:0] n);
		logic [63:0] wide;
		logic [31:0] carrier;
		logic [31:0] rotation;
		logic [31:0] mod_phase;
		longint one_minus;
		longint c;
		longint v;
		wide = 64'(n) * 64'(cfg_carrier);
		carrier = wide[31:0];
		wide = 64'(n) * 64'(cfg_rotation);
		rotation = wide[31:0];
		one_minus = Q30_ONE - phase_cosine(rotation);
		wide = 64'(cfg_depth) * 64'(unsigned'(one_minus));
		// Q54 phase in turns, down to turns scaled by 2^32; whole turns fall away.
		mod_phase = wide[53:22];
		c = phase_cosine(carrier - mod_phase);
		v = (c + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		if (v > WAVE_LIMIT) begin
			v = WAVE_LIMIT;
		end
		if (v < -WAVE_LIMIT) begin
			v = -WAVE_LIMIT;
		end
		return v[WAVE_W-1:0];
	endfunction

	// Request driver: records the expected sample at each accepted request and
	// offers the next pending index, idling at random unless steady is set.
	always @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			expected_waves.push_back(predict_wave(sample_index));
		end
		if (!sample_valid || sample_ready) begin
			if (pending_indices.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PERCENT)) begin
				sample_valid <= 1'b1;
				sample_index <= pending_indices.pop_front();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Wave monitor: checks each accepted sample against the oldest expectation
	// and stalls at random unless steady is set, with one long hold-off part way through.
	always @(posedge clk) begin
		if (wave_valid && wave_ready) begin
			if (expected_waves.size() == 0) begin
				if (error_count < MAX_REPORTS) begin
					$display("%0t: wave_sample %0d arrived with nothing expected",
						$time, $signed(wave_sample));
				end
				error_count++;
			end else if (wave_sample !== expected_waves[0]) begin
				if (error_count < MAX_REPORTS) begin
					$display("%0t: wave_sample mismatch, expected %0d, got %0d",
						$time, expected_waves[0], $signed(wave_sample));
				end
				error_count++;
				void'(expected_waves.pop_front());
			end else begin
				void'(expected_waves.pop_front());
			end
			waves_seen++;
			if (waves_seen == HOLD_AFTER_WAVES) begin
				hold_left = HOLD_CYCLES;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			wave_ready <= 1'b0;
		end else begin
			wave_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CARRIER_STEP: begin
				cfg_carrier = value;
			end
			REG_ROTATION_STEP: begin
				cfg_rotation = value;
			end
			REG_MOD_DEPTH: begin
				cfg_depth = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_regs(input logic [31:0] carrier, input logic [31:0] rotation,
		input logic [31:0] depth);
		write_reg(REG_CARRIER_STEP, carrier);
		write_reg(REG_ROTATION_STEP, rotation);
		write_reg(REG_MOD_DEPTH, depth);
	endtask

	// Waits until every request has been taken and answered, then lets the
	// pipeline settle. The check is made between edges, once the driver's
	// updates have landed.
	task automatic drain();
		while (pending_indices.size() != 0 || sample_valid || expected_waves.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register value for a random phase, drawn from one of several styles.
	function automatic logic [31:0] pick_value(input int style);
		case (style)
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom >> $urandom_range(0, 31);
			end
			default: begin
				case ($urandom_range(2))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic [IDX_W-1:0] base;
		int p;
		int k;
		int style;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: the unmodulated peak saturates.
		pending_indices.push_back('0);
		pending_indices.push_back('1);
		drain();

		// All registers at their maximum, so the phases of the larger indices wrap.
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		pending_indices.push_back(20'd0);
		pending_indices.push_back(20'd1);
		pending_indices.push_back(20'd2);
		pending_indices.push_back('1);
		pending_indices.push_back(20'h80000);
		drain();

		// A write outside the register map must leave the settings alone.
		write_reg(REG_UNMAPPED, 32'h1234_5678);
		pending_indices.push_back(20'd3);
		pending_indices.push_back(20'hAAAAA);
		drain();

		// Quarter-cycle carrier steps walk through every quadrant.
		set_regs(32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
		for (k = 0; k < 8; k++) begin
			pending_indices.push_back(IDX_W'(k));
		end
		drain();

		// Depth of one cycle with half-cycle rotation: whole cycles are dropped.
		set_regs(32'h0000_0000, 32'h8000_0000, 32'h0100_0000);
		for (k = 0; k < 4; k++) begin
			pending_indices.push_back(IDX_W'(k));
		end
		drain();

		// Random phases: mostly runs of consecutive indices, some scattered ones.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			style = p % 3;
			set_regs(pick_value(style), pick_value(style), pick_value(style));
			steady = (p == 2);
			base = '0;
			for (k = 0; k < PHASE_REQUESTS; k++) begin
				if (k % 40 == 0) begin
					base = IDX_W'($urandom);
				end
				if ($urandom_range(3) == 0) begin
					pending_indices.push_back(IDX_W'($urandom));
				end else begin
					pending_indices.push_back(base + IDX_W'(k));
				end
			end
			drain();
		end
		steady = 1'b0;

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
